### hdl/dedup_fifo_with_remove_unit_assert.svh
// Assertion macros used by the queue's top-level RTL file.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef DEDUP_FIFO_WITH_REMOVE_UNIT_ASSERT_SVH
`define DEDUP_FIFO_WITH_REMOVE_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define DFWR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that, when it holds at one edge, implies a consequence at the next.
`define DFWR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/dfwr_pkg.sv
`default_nettype none

package dfwr_pkg;

	localparam logic [1:0] CMD_ENQ = 2'd0;
	localparam logic [1:0] CMD_DEQ = 2'd1;
	localparam logic [1:0] CMD_REM = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_MISS  = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// Committed operation broadcast to every cell in the chain.
	typedef struct packed {
		logic enq;
		logic deq;
		logic rem;
	} dfwr_op_t;

endpackage

`default_nettype wire

### hdl/dfwr_cell.sv
`default_nettype none

module dfwr_cell #(
	parameter int IDX      = 0,
	parameter int ID_BITS  = 8,
	parameter int CNT_BITS = 5
) (
	input  wire                    clk,
	input  wire dfwr_pkg::dfwr_op_t op,
	input  wire [ID_BITS-1:0]      key,
	input  wire [CNT_BITS-1:0]     fill,
	input  wire [ID_BITS-1:0]      nxt_id,
	input  wire                    seen_in,
	output logic                   seen_out,
	output logic                   hit,
	output logic [ID_BITS-1:0]     id
);
	import dfwr_pkg::*;

	logic               occ;
	logic [ID_BITS-1:0] id_q;

	assign occ      = CNT_BITS'(IDX) < fill;
	assign hit      = occ && (id_q == key);
	// Once a match has been seen at or before this cell, a removal closes the gap here.
	assign seen_out = seen_in | hit;
	assign id       = id_q;

	always_ff @(posedge clk) begin
		if (op.enq && (fill == CNT_BITS'(IDX))) begin
			id_q <= key;
		end else if (op.deq || (op.rem && seen_out)) begin
			id_q <= nxt_id;
		end
	end

endmodule

`default_nettype wire

### hdl/dedup_fifo_with_remove_unit.sv
`default_nettype none
// Ordered queue of identifiers with duplicate rejection and removal by name.
// Input channel (in_valid / in_stall) carries cmd and item_id: enqueue at the
// tail, dequeue the head, or remove a named identifier from any position.
// Output channel (out_valid / out_stall) returns exactly one item per input:
// out_id, status (ok, empty, duplicate or not found, full) and the new count.
// Each command is handled in parallel: every cell compares its entry with the
// identifier at once, and a chain signal from cell to cell marks the cells
// that take their neighbour's entry. The result is captured in an output
// register when the command is accepted and is presented in the cycle after,
// and one item is taken per cycle while the receiver keeps up.
// When the receiver stalls, the result is held and in_stall rises, so at most
// one item waits in the output register and nothing is lost.
// Reset empties the queue and clears out_valid; the entries themselves are
// not cleared, as only entries below the count are ever read.
module dedup_fifo_with_remove_unit #(
	parameter int DEPTH   = 16,
	parameter int ID_BITS = 8
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire [1:0]                       cmd,
	input  wire [ID_BITS-1:0]               item_id,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic [ID_BITS-1:0]              out_id,
	output logic [1:0]                      status,
	output logic [$clog2(DEPTH+1)-1:0]      count
);
	import dfwr_pkg::*;
`include "dedup_fifo_with_remove_unit_assert.svh"

	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [CNT_BITS-1:0] fill_q;
	logic [ID_BITS-1:0]  cell_id [DEPTH+1];
	logic [DEPTH:0]      seen;
	logic [DEPTH-1:0]    match;
	logic                in_fire;
	logic                any_hit;
	logic                full;
	logic                empty;
	logic                enq_ok;
	logic                deq_ok;
	logic                rem_ok;
	dfwr_op_t            op;
	logic [ID_BITS-1:0]  res_id;
	logic [1:0]          res_st;
	logic [CNT_BITS-1:0] fill_nxt;
	logic                out_valid_q;
	logic [ID_BITS-1:0]  out_id_q;
	logic [1:0]          status_q;
	logic [CNT_BITS-1:0] count_q;

	assign in_stall = out_valid_q & out_stall;
	assign in_fire  = in_valid & ~in_stall;

	assign seen[0]        = 1'b0;
	assign cell_id[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dfwr_cell #(
			.IDX      (i),
			.ID_BITS  (ID_BITS),
			.CNT_BITS (CNT_BITS)
		) u_cell (
			.clk      (clk),
			.op       (op),
			.key      (item_id),
			.fill     (fill_q),
			.nxt_id   (cell_id[i+1]),
			.seen_in  (seen[i]),
			.seen_out (seen[i+1]),
			.hit      (match[i]),
			.id       (cell_id[i])
		);
	end

	assign any_hit = |match;
	assign full    = fill_q == CNT_BITS'(DEPTH);
	assign empty   = fill_q == '0;
	assign enq_ok  = (cmd == CMD_ENQ) && !any_hit && !full;
	assign deq_ok  = (cmd == CMD_DEQ) && !empty;
	assign rem_ok  = (cmd == CMD_REM) && any_hit;

	assign op.enq = in_fire & enq_ok;
	assign op.deq = in_fire & deq_ok;
	assign op.rem = in_fire & rem_ok;

	always_comb begin
		res_id = '0;
		res_st = ST_MISS;
		case (cmd)
			CMD_ENQ: begin
				if (any_hit) begin
					res_st = ST_MISS;
				end else if (full) begin
					res_st = ST_FULL;
				end else begin
					res_st = ST_OK;
				end
			end
			CMD_DEQ: begin
				if (empty) begin
					res_st = ST_EMPTY;
				end else begin
					res_st = ST_OK;
					res_id = cell_id[0];
				end
			end
			CMD_REM: begin
				// The matching entry equals the key, so the key is the removed identifier.
				if (any_hit) begin
					res_st = ST_OK;
					res_id = item_id;
				end
			end
			default: begin
				res_st = ST_MISS;
			end
		endcase
	end

	always_comb begin
		fill_nxt = fill_q;
		if (enq_ok) begin
			fill_nxt = fill_q + CNT_BITS'(1);
		end else if (deq_ok || rem_ok) begin
			fill_nxt = fill_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				fill_q <= fill_nxt;
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_id_q <= res_id;
			status_q <= res_st;
			count_q  <= fill_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_id    = out_id_q;
	assign status    = status_q;
	assign count     = count_q;

	`DFWR_ASSERT_ALWAYS(a_no_dup, $onehot0(match), "identifier stored in more than one cell")
	`DFWR_ASSERT_ALWAYS(a_fill_range, fill_q <= CNT_BITS'(DEPTH), "fill count beyond depth")
	`DFWR_ASSERT_NEXT(a_count_tracks, in_fire, out_valid && (count == fill_q), "count off")
	`DFWR_ASSERT_NEXT(a_rem_id, in_fire && rem_ok, out_id == $past(item_id) && status == ST_OK, "bad removal")

endmodule

`default_nettype wire
